/* rtl/plw_pkg.sv */
// ----------------------------------------------------------------------------
// plw_pkg
// Shared types, constants and the constant table of the power-law shaper.
// ----------------------------------------------------------------------------
`default_nettype none

package plw_pkg;

	localparam int unsigned MAX_SAMPLES = 8192;
	localparam int unsigned CNT_W = 14;
	localparam int unsigned SUM_W = 29;
	localparam int unsigned EXP_W = 6;
	localparam int unsigned EXP_MIN = 10;
	localparam int unsigned EXP_MAX = 60;
	localparam int unsigned EXP_RESET = 20;
	localparam int unsigned LEVEL_MAX = 65536;
	localparam int unsigned DIV_W = 31;
	localparam int unsigned Q30_W = 31;

	// Division by 20 is a shift by two followed by a reciprocal multiply by 1/5.
	localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;
	localparam int unsigned RECIP5_SHIFT = 34;

	typedef logic [15:0][Q30_W-1:0] dtab_t;

	typedef struct packed {
		logic       load;
		logic       log_step;
		logic       zdiv_load;
		logic       zmul;
		logic       div_step;
		logic       exp_step;
		logic [3:0] step_idx;
		logic       fin;
		logic       ldiv_load;
		logic       out_load;
	} plw_cmd_t;

	typedef struct packed {
		logic last;
	} plw_sts_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem_v;
		logic [63:0] res;
		logic [63:0] bit_v;
		rem_v = v;
		res = '0;
		bit_v = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem_v >= res + bit_v) begin
				rem_v = rem_v - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// Entry k holds 2^(-2^-(k+1)) in Q30.
	function automatic dtab_t build_pow_d();
		dtab_t tab;
		logic [63:0] d;
		d = isqrt64(64'd1 << 59);
		tab[0] = d[Q30_W-1:0];
		for (int k = 1; k < 16; k++) begin
			d = isqrt64(d << 30);
			tab[k] = d[Q30_W-1:0];
		end
		return tab;
	endfunction

	localparam dtab_t POW_D = build_pow_d();

endpackage

`default_nettype wire

/* rtl/plw_in_if.sv */
// ----------------------------------------------------------------------------
// plw_in_if
// Request channel carrying one audio sample and its end-of-buffer mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface plw_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic               last_of_buffer;

	modport source (output valid, output sample, output last_of_buffer, input ready);
	modport sink (input valid, input sample, input last_of_buffer, output ready);
endinterface

`default_nettype wire

/* rtl/plw_out_if.sv */
// ----------------------------------------------------------------------------
// plw_out_if
// Result channel carrying the shaped sample and the buffer level.
// ----------------------------------------------------------------------------
`default_nettype none

interface plw_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] shaped_sample;
	logic               level_valid;
	logic [16:0]        level;

	modport source (output valid, output shaped_sample, output level_valid,
		output level, input ready);
	modport sink (input valid, input shaped_sample, input level_valid,
		input level, output ready);
endinterface

`default_nettype wire

/* rtl/plw_ctrl.sv */
// ----------------------------------------------------------------------------
// plw_ctrl
// Sequencer stepping the datapath through log, divide, exp and level phases.
// ----------------------------------------------------------------------------
`default_nettype none

module plw_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output plw_pkg::plw_cmd_t      cmd,
	input  wire plw_pkg::plw_sts_t sts
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LOG  = 4'd1;
	localparam logic [3:0] S_ZLD  = 4'd2;
	localparam logic [3:0] S_ZDIV = 4'd3;
	localparam logic [3:0] S_EXP  = 4'd4;
	localparam logic [3:0] S_FIN  = 4'd5;
	localparam logic [3:0] S_LLD  = 4'd6;
	localparam logic [3:0] S_LDIV = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [4:0] step_q;
	logic [4:0] step_d;
	logic       out_valid_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		step_d = step_q + 5'd1;
		cmd = '0;
		cmd.step_idx = step_q[3:0];
		unique case (state_q)
			S_IDLE: begin
				step_d = '0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_LOG;
				end
			end
			S_LOG: begin
				cmd.log_step = 1'b1;
				if (step_q == 5'd15) state_d = S_ZLD;
			end
			S_ZLD: begin
				cmd.zdiv_load = 1'b1;
				step_d = '0;
				state_d = S_ZDIV;
			end
			S_ZDIV: begin
				cmd.zmul = 1'b1;
				step_d = '0;
				state_d = S_EXP;
			end
			S_EXP: begin
				cmd.exp_step = 1'b1;
				if (step_q == 5'd15) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = sts.last ? S_LLD : S_OUT;
			end
			S_LLD: begin
				cmd.ldiv_load = 1'b1;
				step_d = '0;
				state_d = S_LDIV;
			end
			S_LDIV: begin
				cmd.div_step = 1'b1;
				if (step_q == 5'(plw_pkg::DIV_W - 1)) state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_LOG && step_q == 5'd0))
		else $error("accepted request did not start the log phase");
	a_exp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXP || state_q == S_LOG) |-> (step_q < 5'd16))
		else $error("step counter out of range");
`endif

endmodule

`default_nettype wire

/* rtl/plw_datapath.sv */
// ----------------------------------------------------------------------------
// plw_datapath
// Log by squaring, reciprocal exponent scaling, exp by constant products, meter.
// ----------------------------------------------------------------------------
`default_nettype none

module plw_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [5:0]         cfg_data,
	input  wire logic signed [15:0] in_sample,
	input  wire logic               in_last,
	input  wire plw_pkg::plw_cmd_t  cmd,
	output plw_pkg::plw_sts_t       sts,
	output logic signed [15:0]      out_shaped,
	output logic                    out_level_valid,
	output logic [16:0]             out_level
);

	logic [plw_pkg::EXP_W-1:0] exp_q;
	logic [plw_pkg::SUM_W-1:0] sum_q;
	logic [plw_pkg::CNT_W-1:0] cnt_q;

	logic                      neg_q;
	logic                      last_q;
	logic                      zero_q;
	logic [3:0]                p_q;
	logic [30:0]               x_q;
	logic [15:0]               frac_q;
	logic [30:0]               quo_q;
	logic [13:0]               rem_q;
	logic [13:0]               dsr_q;
	logic [30:0]               prod_q;
	logic [15:0]               y_q;
	logic signed [15:0]        shaped_q;
	logic                      lvl_valid_q;
	logic [16:0]               level_q;

	logic [16:0]               m_in;
	logic [3:0]                p_in;
	logic [5:0]                n_cl;
	logic [61:0]               sq;
	logic [19:0]               t_val;
	logic [26:0]               zdividend;
	logic [55:0]               zprod;
	logic [14:0]               trial;
	logic                      trial_ge;
	logic [60:0]               pmul;
	logic [60:0]               pround;
	logic [5:0]                zi;
	logic [46:0]               sh_num;
	logic [46:0]               sh_res;
	logic [15:0]               y_val;
	logic [29:0]               sum_ext;
	logic [30:0]               ldividend;
	logic [16:0]               lvl_sat;

	assign sts.last = last_q;
	assign out_shaped = shaped_q;
	assign out_level_valid = lvl_valid_q;
	assign out_level = level_q;

	always_comb begin
		m_in = in_sample[15] ? (17'h10000 - {1'b0, in_sample}) : {1'b0, in_sample};
		p_in = '0;
		for (int i = 1; i < 16; i++) begin
			if (m_in[16:0] >> i != 17'd0) p_in = 4'(i);
		end
		if (m_in[16]) p_in = 4'd15;
	end

	always_comb begin
		if (exp_q < 6'(plw_pkg::EXP_MIN)) n_cl = 6'(plw_pkg::EXP_MIN);
		else if (exp_q > 6'(plw_pkg::EXP_MAX)) n_cl = 6'(plw_pkg::EXP_MAX);
		else n_cl = exp_q;
	end

	assign sq = 62'(x_q) * 62'(x_q);
	assign t_val = (20'd15 << 16) - {p_q, frac_q};
	assign zdividend = 27'(t_val) * 27'(n_cl) + 27'd10;
	assign zprod = 56'(quo_q[23:0]) * 56'(plw_pkg::RECIP5);

	assign trial = {rem_q, quo_q[30]};
	assign trial_ge = (trial >= {1'b0, dsr_q});

	assign pmul = 61'(prod_q) * 61'(plw_pkg::POW_D[cmd.step_idx]);
	assign pround = pmul + (61'd1 << 29);

	// After the z divide, quo_q holds z with integer part in bits 16 and above.
	assign zi = (quo_q[30:16] > 15'd16) ? 6'd63 : quo_q[21:16];
	always_comb begin
		sh_num = {1'b0, prod_q, 15'b0} + (47'd1 << (29 + 5'(zi[4:0])));
		sh_res = sh_num >> (30 + 6'(zi[4:0]));
		if (zero_q || zi > 6'd16) y_val = '0;
		else if (sh_res > 47'd32767) y_val = 16'd32767;
		else y_val = sh_res[15:0];
	end

	assign sum_ext = {sum_q, 1'b0};
	assign ldividend = 31'(sum_ext) + 31'(cnt_q >> 1);
	assign lvl_sat = (quo_q > 31'(plw_pkg::LEVEL_MAX)) ? 17'(plw_pkg::LEVEL_MAX)
		: quo_q[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= 6'(plw_pkg::EXP_RESET);
			sum_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) exp_q <= cfg_data;
			if (cmd.fin && cnt_q < 14'(plw_pkg::MAX_SAMPLES)) begin
				if (30'(sum_q) + 30'(y_val) > 30'({plw_pkg::SUM_W{1'b1}}))
					sum_q <= '1;
				else
					sum_q <= sum_q + 29'(y_val);
				cnt_q <= cnt_q + 14'd1;
			end
			if (cmd.out_load && last_q) begin
				sum_q <= '0;
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= in_sample[15];
			last_q <= in_last;
			zero_q <= (m_in == 17'd0);
			p_q <= p_in;
			x_q <= 31'(m_in) << (30 - 5'(p_in));
			frac_q <= '0;
		end
		if (cmd.log_step) begin
			if (sq[61]) begin
				x_q <= sq[61:31];
				frac_q <= {frac_q[14:0], 1'b1};
			end else begin
				x_q <= sq[60:30];
				frac_q <= {frac_q[14:0], 1'b0};
			end
		end
		if (cmd.zdiv_load) begin
			quo_q <= 31'(zdividend >> 2);
			prod_q <= 31'd1 << 30;
		end
		if (cmd.zmul) quo_q <= 31'(zprod >> plw_pkg::RECIP5_SHIFT);
		if (cmd.ldiv_load) begin
			quo_q <= ldividend;
			rem_q <= '0;
			dsr_q <= cnt_q;
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? 14'(trial - {1'b0, dsr_q}) : trial[13:0];
			quo_q <= {quo_q[29:0], trial_ge};
		end
		if (cmd.exp_step) begin
			if (quo_q[15 - cmd.step_idx]) prod_q <= pround[60:30];
		end
		if (cmd.fin) y_q <= y_val;
		if (cmd.out_load) begin
			shaped_q <= neg_q ? 16'(16'd0 - y_q) : y_q;
			lvl_valid_q <= last_q;
			level_q <= last_q ? lvl_sat : 17'd0;
		end
	end

endmodule

`default_nettype wire

/* rtl/power_law_waveshaper_level_meter_top.sv */
// ----------------------------------------------------------------------------
// power_law_waveshaper_level_meter_top
// Sign-preserving power-law shaper with a per-buffer average level meter.
// ----------------------------------------------------------------------------
// Channel   Role    Payload
// samples   sink    sample, last_of_buffer
// shaped    source  shaped_sample, level_valid, level
// cfg       write   exponent_twentieths (cfg_we, cfg_data)
//
// A sample passes from acceptance to a loaded result through 16 log squaring
// steps, a load and a reciprocal multiply for the exponent scaling, 16 exp
// product steps and a finishing step. A sample marked last adds the level
// division on the serial restoring divider.
// A result waits in the output register while the next sample is worked on.
// Reset restores the exponent to 20 and clears the level accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module power_law_waveshaper_level_meter_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic [5:0] cfg_data,
	plw_in_if.sink     samples,
	plw_out_if.source  shaped
);

	plw_pkg::plw_cmd_t cmd;
	plw_pkg::plw_sts_t sts;

	plw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (shaped.valid),
		.out_ready (shaped.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	plw_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.in_sample       (samples.sample),
		.in_last         (samples.last_of_buffer),
		.cmd             (cmd),
		.sts             (sts),
		.out_shaped      (shaped.shaped_sample),
		.out_level_valid (shaped.level_valid),
		.out_level       (shaped.level)
	);

endmodule

`default_nettype wire
